FILE: src/dsmd_pkg.sv
// ----------------------------------------------------------------------------
// dsmd_pkg
// shared types and constants of the daily spike / median detector
// ----------------------------------------------------------------------------
package dsmd_pkg;

   // fixed field widths
   localparam int DAY_BITS    = 48;
   localparam int VALUE_BITS  = 56;
   localparam int FRAC_BITS   = 8;
   localparam int MIN_BITS    = 5;
   localparam int FACTOR_BITS = 4;

   // divider retires this many quotient bits per cycle while it is stepped
   localparam int DIV_DIGIT = 4;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_PRIOR_DAYS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPIKE_FACTOR   = 1'd1;

   localparam logic [MIN_BITS-1:0]    MIN_PRIOR_RESET    = 5'd7;
   localparam logic [FACTOR_BITS-1:0] SPIKE_FACTOR_RESET = 4'd2;

   typedef struct packed {
      logic [DAY_BITS-1:0] day_total;
      logic                day_known;
   } req_payload_type;

   typedef struct packed {
      logic                  average_valid;
      logic [VALUE_BITS-1:0] average_value;
      logic                  high_day;
   } rsp_payload_type;

   // controls broadcast to every history cell
   typedef struct packed {
      logic capture;  // freeze own entry as candidate, clear rank counters
      logic shift;    // take the left neighbor's entry
      logic count;    // rank the entry passing through against the candidate
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SETTLE,
      S_MUL,
      S_DONE
   } state_type;

endpackage

FILE: src/dsmd_cell.sv
// ----------------------------------------------------------------------------
// dsmd_cell
// one history entry with its candidate rank counters and median pass-through
// ----------------------------------------------------------------------------
module dsmd_cell #(
   parameter int TOTAL_BITS = 48,
   parameter int CNT_BITS   = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dsmd_pkg::cell_ctrl_type ctrl,
   input  logic [TOTAL_BITS-1:0]   left_total,
   input  logic                    left_known,
   input  logic [CNT_BITS-1:0]     rank,
   input  logic [TOTAL_BITS-1:0]   left_median,
   output logic [TOTAL_BITS-1:0]   total,
   output logic                    known,
   output logic [TOTAL_BITS-1:0]   median
);
   import dsmd_pkg::*;

   logic [TOTAL_BITS-1:0] total_ff;
   logic                  known_ff;
   logic [TOTAL_BITS-1:0] cand_ff;
   logic                  cand_known_ff;
   logic [CNT_BITS-1:0]   less_ff;
   logic [CNT_BITS-1:0]   leq_ff;
   logic [TOTAL_BITS-1:0] median_ff;
   logic [TOTAL_BITS-1:0] median_in;
   logic                  match;

   // candidate is the selected order statistic
   assign match     = cand_known_ff && (less_ff <= rank) && (rank < leq_ff);
   assign median_in = match ? cand_ff : left_median;

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= 1'b0;
      end else if (ctrl.shift) begin
         known_ff <= left_known;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         total_ff <= left_total;
      end
      if (ctrl.capture) begin
         cand_ff       <= total_ff;
         cand_known_ff <= known_ff;
         less_ff       <= '0;
         leq_ff        <= '0;
      end else if (ctrl.count && known_ff) begin
         less_ff <= less_ff + CNT_BITS'(total_ff < cand_ff);
         leq_ff  <= leq_ff + CNT_BITS'(total_ff <= cand_ff);
      end
      median_ff <= median_in;
   end

   assign total  = total_ff;
   assign known  = known_ff;
   assign median = median_ff;

endmodule

FILE: src/dsmd_divider.sv
// ----------------------------------------------------------------------------
// dsmd_divider
// digit-serial restoring divider by a small constant, DIV_DIGIT bits per stepped cycle
// ----------------------------------------------------------------------------
module dsmd_divider #(
   parameter int QUO_BITS = 60,
   parameter int DIVISOR  = 7
) (
   input  logic                clock,
   input  logic                load,
   input  logic                step,
   input  logic [QUO_BITS-1:0] dividend,
   output logic [QUO_BITS-1:0] quotient
);
   import dsmd_pkg::*;

   localparam int REM_BITS = $clog2(DIVISOR + 1);
   localparam logic [REM_BITS:0] DIV_C = (REM_BITS + 1)'(DIVISOR);

   // dividend bits leave at the top, quotient bits enter at the bottom
   logic [QUO_BITS-1:0]  quo_ff;
   logic [QUO_BITS-1:0]  quo_in;
   logic [REM_BITS-1:0]  rem_ff;
   logic [REM_BITS-1:0]  rem_in;
   logic [DIV_DIGIT-1:0] digit;

   always_comb begin
      logic [REM_BITS:0] trial;
      rem_in = rem_ff;
      digit  = '0;
      for (int i = 0; i < DIV_DIGIT; i++) begin
         trial = {rem_in, quo_ff[QUO_BITS-1-i]};
         if (trial >= DIV_C) begin
            trial                 = trial - DIV_C;
            digit[DIV_DIGIT-1-i]  = 1'b1;
         end
         rem_in = trial[REM_BITS-1:0];
      end
      quo_in = {quo_ff[QUO_BITS-DIV_DIGIT-1:0], digit};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;

endmodule

FILE: src/daily_spike_median_detector_unit.sv
// ----------------------------------------------------------------------------
// daily_spike_median_detector_unit
// seven-day moving average and prior-median spike flag over a day history
// ----------------------------------------------------------------------------
// One day is taken per transfer and one result leaves per day. The block takes
// a day only when idle and takes no new day until the current one has gone
// through the scan, settle, multiply and done states. In the history chain
// every cell ranks its entry against all others as the history rotates once
// around the chain, then the rank match walks down the chain to the last cell,
// one cell a cycle, while the averaging divider retires four quotient bits a
// cycle. A finished result waits in the output register, so the next day is
// taken while it is still stalled. The history starts out all unknown after
// reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module daily_spike_median_detector_unit #(
   parameter int HISTORY_DAYS = 28,
   parameter int AVERAGE_DAYS = 7,
   parameter int TOTAL_BITS   = 48
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  dsmd_pkg::req_payload_type               req_payload,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output dsmd_pkg::rsp_payload_type               rsp_payload,
   // configuration writes
   input  logic                                    csr_write_en,
   input  logic [dsmd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dsmd_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);
   import dsmd_pkg::*;

   // widths derived from the parameters
   localparam int CNT_BITS   = $clog2(HISTORY_DAYS + 1);
   localparam int SUM_BITS   = TOTAL_BITS + $clog2(AVERAGE_DAYS);
   localparam int DIV_STEPS  = (SUM_BITS + FRAC_BITS + DIV_DIGIT - 1) / DIV_DIGIT;
   localparam int QUO_BITS   = DIV_STEPS * DIV_DIGIT;
   localparam int PHASE_MAX  = (HISTORY_DAYS > DIV_STEPS) ? HISTORY_DAYS : DIV_STEPS;
   localparam int STEP_BITS  = $clog2(PHASE_MAX);
   localparam int PROD_BITS  = TOTAL_BITS + FACTOR_BITS;
   localparam int CMP_BITS   = (CNT_BITS > MIN_BITS) ? CNT_BITS : MIN_BITS;
   localparam int AVG_BACK   = AVERAGE_DAYS - 1;
   // the average window reaches past the history: never valid
   localparam bit AVG_FITS   = (AVG_BACK <= HISTORY_DAYS);

   // configuration registers
   logic [MIN_BITS-1:0]    min_prior_ff;
   logic [FACTOR_BITS-1:0] factor_ff;

   // sequencer
   state_type              state_ff;
   state_type              state_in;
   logic [STEP_BITS-1:0]   step_ff;
   logic [STEP_BITS-1:0]   step_in;
   cell_ctrl_type          ctrl;
   logic                   push;
   logic                   div_load;
   logic                   div_step;
   logic                   out_load;
   logic                   accept;

   // current day
   logic [TOTAL_BITS-1:0]  day_total_ff;
   logic                   day_known_ff;
   logic [TOTAL_BITS-1:0]  in_total;

   // scan accumulators
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUM_BITS-1:0]    sum_in;
   logic                   avg_ok_ff;
   logic                   avg_ok_in;
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;
   logic                   in_window;

   // history chain
   logic [TOTAL_BITS-1:0]  cell_total  [HISTORY_DAYS];
   logic                   cell_known  [HISTORY_DAYS];
   logic [TOTAL_BITS-1:0]  cell_median [HISTORY_DAYS];
   logic [TOTAL_BITS-1:0]  head_total;
   logic                   head_known;
   logic [CNT_BITS-1:0]    rank;
   logic [TOTAL_BITS-1:0]  median;

   // result path
   logic [QUO_BITS-1:0]    dividend;
   logic [QUO_BITS-1:0]    quotient;
   logic [QUO_BITS+VALUE_BITS-1:0] quo_ext;
   logic                   quo_over;
   logic [PROD_BITS-1:0]   prod_ff;
   logic                   high_day;
   logic [VALUE_BITS-1:0]  avg_value;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_payload_ff;

   // take the day total modulo 2^TOTAL_BITS, zero-extended where wider
   logic [DAY_BITS+TOTAL_BITS-1:0] day_ext;
   assign day_ext  = {TOTAL_BITS'(0), req_payload.day_total};
   assign in_total = day_ext[TOTAL_BITS-1:0];

   assign accept = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_prior_ff <= MIN_PRIOR_RESET;
         factor_ff    <= SPIKE_FACTOR_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_PRIOR_DAYS: min_prior_ff <= csr_write_data[MIN_BITS-1:0];
            CSR_SPIKE_FACTOR:   factor_ff    <= csr_write_data[FACTOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_stall = 1'b1;
      ctrl      = '0;
      push      = 1'b0;
      div_load  = 1'b0;
      div_step  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               // freeze every entry as a median candidate
               ctrl.capture = 1'b1;
               step_in      = STEP_BITS'(HISTORY_DAYS - 1);
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // one full rotation: every entry passes every cell once
            ctrl.shift = 1'b1;
            ctrl.count = 1'b1;
            if (step_ff == '0) begin
               div_load = 1'b1;
               step_in  = STEP_BITS'(PHASE_MAX - 1);
               state_in = S_SETTLE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_SETTLE: begin
            // median walks down the chain, divider runs alongside
            div_step = (step_ff >= STEP_BITS'(PHASE_MAX - DIV_STEPS));
            if (step_ff == '0) begin
               state_in = S_MUL;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_MUL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for the output register, then store the day in the history
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load   = 1'b1;
               push       = 1'b1;
               ctrl.shift = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   // ------------------------------------------------------------------
   // scan accumulators: the last cell holds entry step_ff during the scan,
   // entry 0 being the day just before the current one
   // ------------------------------------------------------------------
   assign in_window = (int'(step_ff) < AVG_BACK);

   always_comb begin
      sum_in    = sum_ff;
      avg_ok_in = avg_ok_ff;
      count_in  = count_ff;
      if (accept) begin
         sum_in    = SUM_BITS'(in_total);
         avg_ok_in = req_payload.day_known && AVG_FITS;
         count_in  = '0;
      end else if (state_ff == S_SCAN) begin
         count_in = count_ff + CNT_BITS'(cell_known[HISTORY_DAYS-1]);
         if (in_window) begin
            if (!cell_known[HISTORY_DAYS-1]) begin
               avg_ok_in = 1'b0;
            end
            sum_in = sum_ff + SUM_BITS'(cell_total[HISTORY_DAYS-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      avg_ok_ff <= avg_ok_in;
      count_ff  <= count_in;
      if (accept) begin
         day_total_ff <= in_total;
         day_known_ff <= req_payload.day_known;
      end
   end

   // ------------------------------------------------------------------
   // history chain: cell 0 holds the newest day; it is fed by the new day
   // on a push and by the last cell while rotating
   // ------------------------------------------------------------------
   assign head_total = push ? day_total_ff : cell_total[HISTORY_DAYS-1];
   assign head_known = push ? day_known_ff : cell_known[HISTORY_DAYS-1];
   // upper median of the known prior days
   assign rank       = count_ff >> 1;

   for (genvar c = 0; c < HISTORY_DAYS; c++) begin : g_cell
      logic [TOTAL_BITS-1:0] left_total;
      logic                  left_known;
      logic [TOTAL_BITS-1:0] left_median;
      if (c == 0) begin : g_head
         assign left_total  = head_total;
         assign left_known  = head_known;
         assign left_median = '0;
      end else begin : g_body
         assign left_total  = cell_total[c-1];
         assign left_known  = cell_known[c-1];
         assign left_median = cell_median[c-1];
      end
      dsmd_cell #(
         .TOTAL_BITS (TOTAL_BITS),
         .CNT_BITS   (CNT_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_total  (left_total),
         .left_known  (left_known),
         .rank        (rank),
         .left_median (left_median),
         .total       (cell_total[c]),
         .known       (cell_known[c]),
         .median      (cell_median[c])
      );
   end

   // all matching cells carry the same value, so the last cell has it
   assign median = cell_median[HISTORY_DAYS-1];

   // ------------------------------------------------------------------
   // average: floor(sum * 256 / AVERAGE_DAYS), saturated to the field
   // ------------------------------------------------------------------
   assign dividend = QUO_BITS'({sum_in, FRAC_BITS'(0)});

   dsmd_divider #(
      .QUO_BITS (QUO_BITS),
      .DIVISOR  (AVERAGE_DAYS)
   ) u_divider (
      .clock    (clock),
      .load     (div_load),
      .step     (div_step),
      .dividend (dividend),
      .quotient (quotient)
   );

   assign quo_ext   = {VALUE_BITS'(0), quotient};
   assign quo_over  = |quo_ext[QUO_BITS+VALUE_BITS-1:VALUE_BITS];
   assign avg_value = !avg_ok_ff ? '0 :
                      quo_over   ? '1 : quo_ext[VALUE_BITS-1:0];

   // ------------------------------------------------------------------
   // spike test
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         prod_ff <= PROD_BITS'(factor_ff) * PROD_BITS'(median);
      end
   end

   assign high_day = (count_ff != '0)
                  && (CMP_BITS'(count_ff) >= CMP_BITS'(min_prior_ff))
                  && (median != '0)
                  && (PROD_BITS'(day_total_ff) > prod_ff);

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_payload_ff.average_valid <= avg_ok_ff;
         rsp_payload_ff.average_value <= avg_value;
         rsp_payload_ff.high_day      <= high_day;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: test/tb_daily_spike_median_detector_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_daily_spike_median_detector_unit
// self-checking bench for the seven-day average and prior-median spike flag
// ----------------------------------------------------------------------------
// Days are sent one transfer at a time, and each accepted day is run through
// a behavioral copy of the day history. The copy works out the average, its
// valid flag and the spike flag. Every result transfer is checked field by
// field against the oldest expected result. The stimulus runs a short
// directed part, a sweep over threshold settings that includes the extremes,
// a gap-free stream, a long output hold-off and a full drain pause. Both
// sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_daily_spike_median_detector_unit;
   import dsmd_pkg::*;

   localparam int HISTORY_LEN   = 28;      // days kept in the history ring
   localparam int WEEK_LEN      = 7;       // days in the moving average
   localparam int STALL_PERCENT = 27;      // share of cycles with a gap
   localparam int HOLD_CYCLES   = 400;     // long output hold-off
   localparam int SETTLE_CYCLES = 80;      // quiet time after the last result
   localparam int WATCHDOG_MAX  = 4000;    // cycles without any transfer

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, all known from time zero
   logic            req_valid      = 1'b0;
   req_payload_type req_payload    = '0;
   logic            rsp_stall      = 1'b0;
   logic            csr_write_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index      = CSR_MIN_PRIOR_DAYS;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   // block outputs
   logic            req_stall;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;

   // behavioral copy of the block state and its thresholds
   logic [DAY_BITS-1:0]    history_total [HISTORY_LEN];
   bit                     history_known [HISTORY_LEN];
   int unsigned            history_head = 0;
   logic [MIN_BITS-1:0]    cfg_min_prior = MIN_PRIOR_RESET;
   logic [FACTOR_BITS-1:0] cfg_factor    = SPIKE_FACTOR_RESET;

   // results still owed by the block, oldest first
   rsp_payload_type expected_days [$];

   // gap control for both sides
   bit sender_gaps   = 1'b1;
   bit receiver_gaps = 1'b1;
   int hold_request  = 0;
   int hold_left     = 0;

   int fail_count    = 0;
   int quiet_cycles  = 0;

   daily_spike_median_detector_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // expected result of one day; updates the history copy like the block
   // ---------------------------------------------------------------------
   function automatic rsp_payload_type predict_day(input req_payload_type day);
      rsp_payload_type     res;
      logic [63:0]         week_sum;
      logic [DAY_BITS-1:0] ranked [HISTORY_LEN];
      logic [DAY_BITS-1:0] entry;
      logic [DAY_BITS-1:0] median;
      int unsigned         n_known;
      int                  slot;
      int                  i;
      int                  j;
      bit                  week_ok;

      // current day plus the six before it, all of them must be known
      week_sum = 64'(day.day_total);
      week_ok  = day.day_known;
      for (i = 1; i < WEEK_LEN; i++) begin
         slot = (history_head + HISTORY_LEN - i) % HISTORY_LEN;
         if (!history_known[slot]) begin
            week_ok = 1'b0;
         end
         week_sum += 64'(history_total[slot]);
      end
      res.average_valid = week_ok;
      res.average_value = week_ok ? VALUE_BITS'((week_sum << FRAC_BITS) / 64'(WEEK_LEN)) : '0;

      // known prior days in ascending order, insertion sort
      n_known = 0;
      for (i = 1; i <= HISTORY_LEN; i++) begin
         slot = (history_head + HISTORY_LEN - i) % HISTORY_LEN;
         if (history_known[slot]) begin
            entry = history_total[slot];
            j = n_known;
            while (j > 0 && ranked[j-1] > entry) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = entry;
            n_known++;
         end
      end

      // upper median; no spike without known days or with a zero median
      res.high_day = 1'b0;
      if (n_known > 0 && n_known >= cfg_min_prior) begin
         median = ranked[n_known / 2];
         if (median != '0 && 64'(day.day_total) > 64'(cfg_factor) * 64'(median)) begin
            res.high_day = 1'b1;
         end
      end

      // the day replaces the oldest entry, unknown days included
      history_total[history_head] = day.day_total;
      history_known[history_head] = day.day_known;
      history_head = (history_head + 1) % HISTORY_LEN;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // typical daily level, kept at or below 2^40 so that spikes never wrap
   function automatic logic [DAY_BITS-1:0] random_level();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return (raw[DAY_BITS-1:0] >> $urandom_range(8, 47)) + 1;
   endfunction

   // one day around the level: mostly plausible values, some spikes and noise
   function automatic req_payload_type random_day(input logic [DAY_BITS-1:0] level);
      req_payload_type day;
      logic [63:0]     noise;
      int unsigned     pick;
      noise = {$urandom(), $urandom()};
      pick  = $urandom_range(99);
      day.day_known = ($urandom_range(99) < 88);
      if (pick < 6) begin
         day.day_total = noise[DAY_BITS-1:0];
      end else if (pick < 9) begin
         day.day_total = '0;
      end else if (pick < 11) begin
         day.day_total = '1;
      end else if (pick < 23) begin
         // above factor times the level, so usually a spike
         day.day_total = DAY_BITS'(64'(level) * (64'(cfg_factor) + 1)
                                   + noise % (64'(level) + 1));
      end else begin
         day.day_total = DAY_BITS'(64'(level) - 64'(level >> 3)
                                   + noise % (64'(level >> 2) + 1));
      end
      return day;
   endfunction

   // one day transfer; starts and ends on a falling edge, leaves valid high
   task automatic send_day(input logic [DAY_BITS-1:0] total, input bit known);
      while (sender_gaps && $urandom_range(99) < STALL_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_payload.day_total <= total;
      req_payload.day_known <= known;
      do begin
         @(posedge clock);
      end while (req_stall);
      // transfer taken at this edge
      expected_days.insert(expected_days.size(),
                           predict_day('{day_total: total, day_known: known}));
      @(negedge clock);
   endtask

   task automatic send_random_days(input int count, inout logic [DAY_BITS-1:0] level);
      req_payload_type day;
      repeat (count) begin
         // the level drifts now and then
         if ($urandom_range(99) < 5) begin
            level = random_level();
         end
         day = random_day(level);
         send_day(day.day_total, day.day_known);
      end
   endtask

   // stop offering days and wait until every owed result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_days.size() != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   // both thresholds are written back to back while the block is idle
   task automatic set_thresholds(input logic [CSR_DATA_BITS-1:0] min_data,
                                 input logic [CSR_DATA_BITS-1:0] factor_data);
      wait_for_results();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_MIN_PRIOR_DAYS;
      csr_write_data <= min_data;
      @(negedge clock);
      csr_index      <= CSR_SPIKE_FACTOR;
      csr_write_data <= factor_data;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      // registers keep only their low bits
      cfg_min_prior = min_data[MIN_BITS-1:0];
      cfg_factor    = factor_data[FACTOR_BITS-1:0];
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset thresholds, zero factor, unknown current day, full-scale average
   task automatic test_directed_days();
      // reset thresholds: min 7 known priors, factor 2
      repeat (6) send_day(48'd100, 1'b1);
      send_day(48'd201, 1'b1);          // only six priors known, no spike yet
      send_day(48'd201, 1'b1);          // seven priors, 201 above twice 100
      // zero factor through the masked high data bit, no prior minimum
      set_thresholds(5'd0, 5'h10);
      send_day(48'd0, 1'b1);            // zero is never above zero
      send_day(48'd5, 1'b0);            // unknown day is still tested
      // minimum above the history size, largest factor
      set_thresholds(5'd31, 5'd15);
      send_day('1, 1'b1);
      // a week of full-scale days for the largest average
      set_thresholds(5'd1, 5'd1);
      repeat (WEEK_LEN) send_day('1, 1'b1);
      send_day(48'd201, 1'b1);
   endtask

   // random traffic under a set of threshold settings, extremes included
   task automatic test_threshold_sweep();
      logic [DAY_BITS-1:0] level;
      level = random_level();

      // no minimum and zero factor, starting from an all-unknown history
      set_thresholds(5'd0, 5'h10);
      repeat (HISTORY_LEN + 2) send_day(DAY_BITS'({$urandom(), $urandom()}), 1'b0);
      send_day(48'd0, 1'b1);            // no known prior day at all
      send_day(48'd9, 1'b1);            // the only prior is zero
      send_day(48'd4, 1'b1);            // median nonzero now
      send_random_days(50, level);

      set_thresholds(5'd31, 5'd15);
      send_random_days(40, level);
      set_thresholds(5'd1, 5'd1);
      send_random_days(60, level);
      set_thresholds(5'd28, 5'd15);
      send_random_days(60, level);
      set_thresholds(5'd7, 5'd2);
      send_random_days(60, level);
      set_thresholds(5'($urandom_range(1, 28)), 5'($urandom_range(1, 15)));
      send_random_days(50, level);
   endtask

   // gap-free stretch on both sides
   task automatic test_steady_stream();
      logic [DAY_BITS-1:0] level;
      level         = random_level();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      send_random_days(80, level);
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // receiver holds off while days keep coming, so the input backs up
   task automatic test_output_backpressure();
      logic [DAY_BITS-1:0] level;
      level        = random_level();
      sender_gaps  = 1'b0;
      hold_request = HOLD_CYCLES;
      send_random_days(10, level);
      sender_gaps  = 1'b1;
   endtask

   // sender stops until the block has returned everything, then resumes
   task automatic test_drain_pause();
      logic [DAY_BITS-1:0] level;
      level = random_level();
      send_random_days(10, level);
      wait_for_results();
      send_random_days(10, level);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < HISTORY_LEN; i++) begin
         history_total[i] = '0;
         history_known[i] = 1'b0;
      end
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_days();
      test_threshold_sweep();
      test_steady_stream();
      test_output_backpressure();
      test_drain_pause();

      // drain, then leave room for any stray result
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_days.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // receiver side: random stall, or a counted hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left    = hold_request - 1;
         hold_request = 0;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_gaps && ($urandom_range(99) < STALL_PERCENT);
      end
   end

   // result check against the oldest expected day
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_days.size() == 0) begin
            $error("result transfer with no day outstanding");
            fail_count++;
         end else begin
            want = expected_days.pop_front();
            if (rsp_payload.average_valid !== want.average_valid) begin
               $error("average_valid expected %0d actual %0d",
                      want.average_valid, rsp_payload.average_valid);
               fail_count++;
            end
            if (rsp_payload.average_value !== want.average_value) begin
               $error("average_value expected %0h actual %0h",
                      want.average_value, rsp_payload.average_value);
               fail_count++;
            end
            if (rsp_payload.high_day !== want.high_day) begin
               $error("high_day expected %0d actual %0d",
                      want.high_day, rsp_payload.high_day);
               fail_count++;
            end
         end
      end
   end

   // watchdog: too long without any transfer or register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
